[src/gaussian_blur_sobel_edge_macros.svh]
// assertion macros for the gaussian blur / sobel edge block
// used by the top level; relies on ports aclk and aresetn being in scope
`ifndef GAUSSIAN_BLUR_SOBEL_EDGE_MACROS_SVH
`define GAUSSIAN_BLUR_SOBEL_EDGE_MACROS_SVH

// same-cycle implication
`define GBSE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GBSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/gbse_pkg.sv]
// shared constants, weights and opcodes for the gaussian blur / sobel edge block
// no dependencies
package gbse_pkg;

    localparam int FRAME_WIDTH  = 512;
    localparam int FRAME_HEIGHT = 512;
    localparam int RING_ROWS    = 8;
    localparam int SLOT_W       = 3;
    localparam int COL_W        = $clog2(FRAME_WIDTH);
    localparam int ROW_W        = $clog2(FRAME_HEIGHT);
    localparam int MEM_DEPTH    = RING_ROWS * FRAME_WIDTH;
    localparam int ADDR_W       = $clog2(MEM_DEPTH);
    localparam int PIX_W        = 8;

    // weighted 5x5 sum is at most 255 * 159
    localparam int SUM_W        = 16;
    // floor(x / 159) == (x * DIV_MUL) >> DIV_SHIFT for x below 55013
    localparam int DIV_MUL_W    = 17;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 17'd105519;
    localparam int DIV_SHIFT    = 24;

    localparam int GRAD_W       = 11;
    localparam int MAG_W        = 22;
    localparam int SQRT_STEPS   = 11;
    localparam int STEP_W       = 4;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // gaussian weight at tap (i, j) of the 5x5 kernel
    function automatic logic [3:0] gauss_w(input logic [2:0] i, input logic [2:0] j);
        logic [1:0] di;
        logic [1:0] dj;
        logic [3:0] w;
        di = (i > 3'd2) ? 2'(3'd4 - i) : i[1:0];
        dj = (j > 3'd2) ? 2'(3'd4 - j) : j[1:0];
        case ({di, dj})
            4'b0000: w = 4'd2;
            4'b0001: w = 4'd4;
            4'b0010: w = 4'd5;
            4'b0100: w = 4'd4;
            4'b0101: w = 4'd9;
            4'b0110: w = 4'd12;
            4'b1000: w = 4'd5;
            4'b1001: w = 4'd12;
            4'b1010: w = 4'd15;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

[src/gbse_ram.sv]
// generic single-port ram with registered read
// no dependencies
module gbse_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[src/gaussian_blur_sobel_edge.sv]
// an accepted transaction whose result is due runs nine 5x5 blur sums at one ram read per tap
// (accumulate, drain, divide each), then an 11-step square root; no result otherwise
// s_ready is high only in idle: a new transaction waits until the previous one is done and its
// result, if any, is loaded into the output register, so output stalls also hold off the input
// reset: aresetn synchronous active low clears position counters and control; no memory clearing
// depends on gbse_pkg, gbse_ram and gaussian_blur_sobel_edge_macros.svh
`include "gaussian_blur_sobel_edge_macros.svh"
module gaussian_blur_sobel_edge (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_opcode,
    input  logic [gbse_pkg::PIX_W-1:0] s_pixel_in,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [gbse_pkg::PIX_W-1:0] m_blurred,
    output logic [gbse_pkg::PIX_W-1:0] m_edge_strength,
    output logic                   m_last_of_frame
);
    import gbse_pkg::*;

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_GRAD  = 3'd5;
    localparam logic [2:0] ST_SQRT  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]        state_reg, state_next;

    // input position and ring slot
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic              ahead_reg, ahead_next;
    // output position and ring slot
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;

    // neighbor (3x3) and tap (5x5) counters
    logic [1:0]        nb_r_reg, nb_r_next;
    logic [1:0]        nb_c_reg, nb_c_next;
    logic [2:0]        tap_i_reg, tap_i_next;
    logic [2:0]        tap_j_reg, tap_j_next;

    // read in flight: tap in frame and its weight
    logic              pend_reg, pend_next;
    logic [3:0]        pend_w_reg, pend_w_next;
    logic [SUM_W-1:0]  acc_reg, acc_next;

    // blurred 3x3 neighborhood
    logic [PIX_W-1:0]  b_reg [3][3];
    logic [PIX_W-1:0]  b_next [3][3];

    // square root unit
    logic [MAG_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]  res_reg, res_next;
    logic [MAG_W-1:0]  bit_reg, bit_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]  m_blurred_reg, m_blurred_next;
    logic [PIX_W-1:0]  m_edge_reg, m_edge_next;
    logic              m_last_reg, m_last_next;

    // ram port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [PIX_W-1:0]  mem_rdata;

    // window tap address
    logic signed [3:0]       row_off, col_off;
    logic signed [ROW_W+1:0] row_pos;
    logic signed [COL_W+1:0] col_pos;
    logic                    tap_ok;
    logic [SLOT_W-1:0]       tap_slot;
    logic [ADDR_W-1:0]       tap_addr;

    // readiness
    logic [ROW_W:0]    need_row;
    logic [COL_W:0]    need_col;
    logic              out_ready;

    // gradient
    logic signed [GRAD_W-1:0] gx, gy;
    logic signed [MAG_W-1:0]  gx_sq, gy_sq;
    logic [SUM_W+DIV_MUL_W-1:0] q_prod;
    logic [MAG_W-1:0]  trial;
    logic              accept, border, last_tap, out_load;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_blurred       = m_blurred_reg;
    assign m_edge_strength = m_edge_reg;
    assign m_last_of_frame = m_last_reg;

    // tap position relative to the output position, -3..3 in each direction
    assign row_off  = 4'(nb_r_reg) + 4'(tap_i_reg) - 4'sd3;
    assign col_off  = 4'(nb_c_reg) + 4'(tap_j_reg) - 4'sd3;
    assign row_pos  = $signed({2'b00, out_row_reg}) + (ROW_W+2)'(row_off);
    assign col_pos  = $signed({2'b00, out_col_reg}) + (COL_W+2)'(col_off);
    // taps outside the frame count as zero
    assign tap_ok   = !row_pos[ROW_W+1] && ($unsigned(row_pos) < (ROW_W+2)'(FRAME_HEIGHT))
                   && !col_pos[COL_W+1] && ($unsigned(col_pos) < (COL_W+2)'(FRAME_WIDTH));
    assign tap_slot = out_slot_reg + SLOT_W'(row_off[SLOT_W-1:0]);
    assign tap_addr = ADDR_W'(tap_slot) * ADDR_W'(FRAME_WIDTH)
                    + ADDR_W'(col_pos[COL_W-1:0]);
    assign last_tap = (tap_i_reg == 3'd4) && (tap_j_reg == 3'd4);

    // result at (row, col) waits for input at (row+3, col+3), clipped to the frame
    always_comb begin
        need_row = {1'b0, out_row_reg} + (ROW_W+1)'(3);
        if (need_row > (ROW_W+1)'(FRAME_HEIGHT - 1)) begin
            need_row = (ROW_W+1)'(FRAME_HEIGHT - 1);
        end
        need_col = {1'b0, out_col_reg} + (COL_W+1)'(3);
        if (need_col > (COL_W+1)'(FRAME_WIDTH - 1)) begin
            need_col = (COL_W+1)'(FRAME_WIDTH - 1);
        end
        out_ready = ahead_reg
                 || ({1'b0, in_row_reg} > need_row)
                 || (({1'b0, in_row_reg} == need_row) && ({1'b0, in_col_reg} > need_col));
    end

    // sobel on the blurred neighborhood
    assign gx = (GRAD_W'(b_reg[0][2]) - GRAD_W'(b_reg[0][0]))
              + 2 * (GRAD_W'(b_reg[1][2]) - GRAD_W'(b_reg[1][0]))
              + (GRAD_W'(b_reg[2][2]) - GRAD_W'(b_reg[2][0]));
    assign gy = (GRAD_W'(b_reg[2][0]) - GRAD_W'(b_reg[0][0]))
              + 2 * (GRAD_W'(b_reg[2][1]) - GRAD_W'(b_reg[0][1]))
              + (GRAD_W'(b_reg[2][2]) - GRAD_W'(b_reg[0][2]));
    assign gx_sq = MAG_W'(gx) * MAG_W'(gx);
    assign gy_sq = MAG_W'(gy) * MAG_W'(gy);

    assign q_prod = (SUM_W+DIV_MUL_W)'(acc_reg) * (SUM_W+DIV_MUL_W)'(DIV_MUL);
    assign trial  = res_reg + bit_reg;
    assign border = (out_row_reg == '0) || (out_row_reg == ROW_W'(FRAME_HEIGHT - 1))
                 || (out_col_reg == '0) || (out_col_reg == COL_W'(FRAME_WIDTH - 1));
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // ram: pixel writes on accept, window reads while accumulating
    assign mem_we   = accept && (s_opcode == OP_PIXEL);
    assign mem_addr = mem_we ? (ADDR_W'(in_slot_reg) * ADDR_W'(FRAME_WIDTH)
                                + ADDR_W'(in_col_reg))
                             : tap_addr;

    always_comb begin
        state_next    = state_reg;
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        ahead_next    = ahead_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        nb_r_next     = nb_r_reg;
        nb_c_next     = nb_c_reg;
        tap_i_next    = tap_i_reg;
        tap_j_next    = tap_j_reg;
        pend_next     = 1'b0;
        pend_w_next   = gauss_w(tap_i_reg, tap_j_reg);
        acc_next      = acc_reg;
        b_next        = b_reg;
        rem_next      = rem_reg;
        res_next      = res_reg;
        bit_next      = bit_reg;
        step_next     = step_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_blurred_next = m_blurred_reg;
        m_edge_next   = m_edge_reg;
        m_last_next   = m_last_reg;

        // previous tap's read data arrives now
        if (pend_reg) begin
            acc_next = acc_reg + SUM_W'(mem_rdata) * SUM_W'(pend_w_reg);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_opcode == OP_PIXEL) begin
                        if (in_col_reg == COL_W'(FRAME_WIDTH - 1)) begin
                            in_col_next  = '0;
                            in_slot_next = in_slot_reg + 1'b1;
                            if (in_row_reg == ROW_W'(FRAME_HEIGHT - 1)) begin
                                in_row_next = '0;
                                ahead_next  = 1'b1;
                            end else begin
                                in_row_next = in_row_reg + 1'b1;
                            end
                        end else begin
                            in_col_next = in_col_reg + 1'b1;
                        end
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                nb_r_next  = '0;
                nb_c_next  = '0;
                tap_i_next = '0;
                tap_j_next = '0;
                acc_next   = '0;
                state_next = out_ready ? ST_ACC : ST_IDLE;
            end
            ST_ACC: begin
                pend_next = tap_ok;
                if (tap_j_reg == 3'd4) begin
                    tap_j_next = '0;
                    tap_i_next = tap_i_reg + 1'b1;
                end else begin
                    tap_j_next = tap_j_reg + 1'b1;
                end
                if (last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // divide by 159 through the reciprocal
                b_next[nb_r_reg][nb_c_reg] = q_prod[DIV_SHIFT +: PIX_W];
                acc_next   = '0;
                tap_i_next = '0;
                tap_j_next = '0;
                state_next = ST_ACC;
                if (nb_c_reg == 2'd2) begin
                    nb_c_next = '0;
                    nb_r_next = nb_r_reg + 1'b1;
                    if (nb_r_reg == 2'd2) begin
                        state_next = ST_GRAD;
                    end
                end else begin
                    nb_c_next = nb_c_reg + 1'b1;
                end
            end
            ST_GRAD: begin
                rem_next   = MAG_W'($unsigned(gx_sq + gy_sq));
                res_next   = '0;
                bit_next   = MAG_W'(1) << (2 * (SQRT_STEPS - 1));
                step_next  = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                // one result bit per cycle
                if (rem_reg >= trial) begin
                    rem_next = rem_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_valid_next   = 1'b1;
                    m_blurred_next = b_reg[1][1];
                    if (border) begin
                        m_edge_next = '0;
                    end else if (res_reg > MAG_W'(255)) begin
                        m_edge_next = 8'd255;
                    end else begin
                        m_edge_next = res_reg[PIX_W-1:0];
                    end
                    m_last_next = (out_row_reg == ROW_W'(FRAME_HEIGHT - 1))
                               && (out_col_reg == COL_W'(FRAME_WIDTH - 1));
                    if (out_col_reg == COL_W'(FRAME_WIDTH - 1)) begin
                        out_col_next  = '0;
                        out_slot_next = out_slot_reg + 1'b1;
                        if (out_row_reg == ROW_W'(FRAME_HEIGHT - 1)) begin
                            out_row_next = '0;
                            ahead_next   = 1'b0;
                        end else begin
                            out_row_next = out_row_reg + 1'b1;
                        end
                    end else begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            ahead_reg    <= 1'b0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            ahead_reg    <= ahead_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        nb_r_reg       <= nb_r_next;
        nb_c_reg       <= nb_c_next;
        tap_i_reg      <= tap_i_next;
        tap_j_reg      <= tap_j_next;
        pend_w_reg     <= pend_w_next;
        acc_reg        <= acc_next;
        b_reg          <= b_next;
        rem_reg        <= rem_next;
        res_reg        <= res_next;
        bit_reg        <= bit_next;
        step_reg       <= step_next;
        m_blurred_reg  <= m_blurred_next;
        m_edge_reg     <= m_edge_next;
        m_last_reg     <= m_last_next;
    end

    // ring of the last RING_ROWS input rows
    gbse_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MEM_DEPTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (s_pixel_in),
        .rdata (mem_rdata)
    );

    `GBSE_ASSERT_SAME(a_tap_range, state_reg == ST_ACC, tap_i_reg < 3'd5 && tap_j_reg < 3'd5 && nb_r_reg < 2'd3 && nb_c_reg < 2'd3, "tap counter out of range")
    `GBSE_ASSERT_NEXT(a_accept_check, accept, state_reg == ST_CHECK, "accepted transaction not checked")
    `GBSE_ASSERT_SAME(a_sqrt_steps, state_reg == ST_SQRT, step_reg < STEP_W'(SQRT_STEPS), "square root overran")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// self-checking testbench for gaussian_blur_sobel_edge: streams pixel and flush transactions,
// predicts blurred pixel and sobel magnitude per position, compares every result in order
// depends on gbse_pkg and the gaussian_blur_sobel_edge rtl
module testbench;
    import gbse_pkg::*;

    localparam int N_RANDOM    = 1830;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 400;

    typedef struct packed {
        logic [PIX_W-1:0] blurred;
        logic [PIX_W-1:0] edge_mag;
        logic             last;
    } blur_edge_t;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pix;
        logic             none_expected;  // flush right after reset: nothing can be ready
    } stim_row_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic             s_opcode = OP_PIXEL;
    logic [PIX_W-1:0] s_pixel_in = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [PIX_W-1:0] m_blurred;
    logic [PIX_W-1:0] m_edge_strength;
    logic             m_last_of_frame;

    gaussian_blur_sobel_edge i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pixel_in      (s_pixel_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_blurred       (m_blurred),
        .m_edge_strength (m_edge_strength),
        .m_last_of_frame (m_last_of_frame)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------- predictor state ----------------
    logic [PIX_W-1:0] pixel_ring [RING_ROWS*FRAME_WIDTH];
    int unsigned      in_row, in_col, out_row, out_col, in_slot, out_slot;
    bit               in_next_frame;
    blur_edge_t       pending_results[$];

    int unsigned err_count   = 0;
    int unsigned n_sent      = 0;
    int unsigned n_results   = 0;
    int unsigned n_flush     = 0;
    int unsigned n_saturated = 0;
    bit          idle_enable = 1'b1;

    // 5x5 gaussian weights, symmetric
    function automatic int unsigned weight(int i, int j);
        int unsigned w1d [5];
        w1d = '{1, 2, 3, 2, 1};
        case (w1d[i] * 10 + w1d[j])
            11: return 2;
            12, 21: return 4;
            13, 31: return 5;
            22: return 9;
            23, 32: return 12;
            default: return 15;
        endcase
    endfunction

    // blurred value at the output position shifted by (dr, dc)
    function automatic int unsigned blur_near(int dr, int dc);
        int unsigned acc;
        int r, c, roff;
        int unsigned slot;
        acc = 0;
        for (int i = 0; i < 5; i++) begin
            roff = dr + i - 2;
            r = int'(out_row) + roff;
            if (r < 0 || r >= FRAME_HEIGHT) continue;
            slot = (out_slot + roff) & (RING_ROWS - 1);
            for (int j = 0; j < 5; j++) begin
                c = int'(out_col) + dc + j - 2;
                if (c < 0 || c >= FRAME_WIDTH) continue;
                acc += pixel_ring[slot*FRAME_WIDTH + c] * weight(i, j);
            end
        end
        return acc / 159;
    endfunction

    function automatic int unsigned floor_sqrt(int unsigned v);
        int unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function automatic bit result_ready();
        longint unsigned need_pos, have_pos;
        int unsigned rr, rc;
        if (in_next_frame) return 1'b1;
        rr = (out_row + 3 > FRAME_HEIGHT - 1) ? FRAME_HEIGHT - 1 : out_row + 3;
        rc = (out_col + 3 > FRAME_WIDTH - 1) ? FRAME_WIDTH - 1 : out_col + 3;
        need_pos = longint'(rr) * FRAME_WIDTH + rc;
        have_pos = longint'(in_row) * FRAME_WIDTH + in_col;
        return have_pos > need_pos;
    endfunction

    // advances the predictor by one accepted transaction, queues the result if any
    function automatic void predict_blur_edge(logic op, logic [PIX_W-1:0] pix);
        blur_edge_t res;
        int b [3][3];
        int gx, gy;
        int unsigned mag;
        if (op == OP_PIXEL) begin
            pixel_ring[in_slot*FRAME_WIDTH + in_col] = pix;
            in_col++;
            if (in_col >= FRAME_WIDTH) begin
                in_col = 0;
                in_slot = (in_slot + 1) & (RING_ROWS - 1);
                in_row++;
                if (in_row >= FRAME_HEIGHT) begin
                    in_row = 0;
                    in_next_frame = 1'b1;
                end
            end
        end
        if (!result_ready()) return;
        res.blurred  = PIX_W'(blur_near(0, 0));
        res.edge_mag = '0;
        if (out_row != 0 && out_row != FRAME_HEIGHT - 1 &&
            out_col != 0 && out_col != FRAME_WIDTH - 1) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    b[r][c] = blur_near(r - 1, c - 1);
            gx = (b[0][2] - b[0][0]) + 2 * (b[1][2] - b[1][0]) + (b[2][2] - b[2][0]);
            gy = (b[2][0] - b[0][0]) + 2 * (b[2][1] - b[0][1]) + (b[2][2] - b[0][2]);
            mag = floor_sqrt(gx * gx + gy * gy);
            if (mag > 255) begin
                n_saturated++;
                mag = 255;
            end
            res.edge_mag = PIX_W'(mag);
        end
        res.last = (out_row == FRAME_HEIGHT - 1 && out_col == FRAME_WIDTH - 1);
        pending_results.push_back(res);
        out_col++;
        if (out_col >= FRAME_WIDTH) begin
            out_col = 0;
            out_slot = (out_slot + 1) & (RING_ROWS - 1);
            out_row++;
            if (out_row >= FRAME_HEIGHT) begin
                out_row = 0;
                in_next_frame = 1'b0;
            end
        end
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("MISMATCH result %0d %s: got %0d expected %0d", n_results, what, got, want);
        err_count++;
    endtask

    // ---------------- monitor: predict on input, check on output ----------------
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        blur_edge_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_blur_edge(s_opcode, s_pixel_in);
                n_sent++;
                if (s_opcode == OP_FLUSH) n_flush++;
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result count", n_results + 1, n_results);
                end else begin
                    want = pending_results.pop_front();
                    if (m_blurred !== want.blurred)
                        report_mismatch("blurred", m_blurred, want.blurred);
                    if (m_edge_strength !== want.edge_mag)
                        report_mismatch("edge_strength", m_edge_strength, want.edge_mag);
                    if (m_last_of_frame !== want.last)
                        report_mismatch("last_of_frame", m_last_of_frame, want.last);
                end
                n_results++;
            end
            // watchdog: no transaction on either side for too long
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog expired with %0d results pending", pending_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!idle_enable)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(99) >= 25);
    end

    // ---------------- driver ----------------
    task automatic send_item(logic op, logic [PIX_W-1:0] pix);
        while (idle_enable && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_pixel_in <= pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // pixel value by row pattern: sharp stripes push the magnitude into saturation
    function automatic logic [PIX_W-1:0] pattern_pixel(int unsigned kind, int unsigned col);
        case (kind)
            0: return PIX_W'($urandom);
            1: return col[3] ? 8'hff : 8'h00;
            2: return col[1] ? 8'hff : 8'h00;
            3: return 8'hff;
            default: return PIX_W'($urandom_range(100, 140));
        endcase
    endfunction

    stim_row_t directed [] = '{
        '{OP_FLUSH, 8'h00, 1'b1},   // flush with nothing ready
        '{OP_FLUSH, 8'hff, 1'b1},   // pixel ignored on flush
        '{OP_PIXEL, 8'h00, 1'b0},   // extremes of the pixel field
        '{OP_PIXEL, 8'hff, 1'b0},
        '{OP_PIXEL, 8'h01, 1'b0},
        '{OP_PIXEL, 8'h80, 1'b0},
        '{OP_PIXEL, 8'h7f, 1'b0},
        '{OP_PIXEL, 8'hfe, 1'b0},
        '{OP_FLUSH, 8'h55, 1'b0},   // flush mid-frame, still nothing ready
        '{OP_PIXEL, 8'haa, 1'b0},
        '{OP_PIXEL, 8'h55, 1'b0}
    };

    initial begin
        int unsigned kind, col_pos;
        in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        in_slot = 0; out_slot = 0; in_next_frame = 1'b0;
        foreach (pixel_ring[k]) pixel_ring[k] = '0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        foreach (directed[k]) begin
            send_item(directed[k].op, directed[k].pix);
            if (directed[k].none_expected && pending_results.size() != 0)
                report_mismatch("result count after early flush", pending_results.size(), 0);
        end

        // random rows: mostly pixel pushes with stripe patterns, some flush noise
        col_pos = directed.size() - 3;
        kind = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (col_pos % FRAME_WIDTH == 0 || $urandom_range(63) == 0)
                kind = $urandom_range(4);
            idle_enable = !(n >= 700 && n < 1000);
            if (n == 1200) begin
                // hold the input until every queued result has drained
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_results.size() != 0) @(posedge aclk);
            end
            if ($urandom_range(99) < 8) begin
                send_item(OP_FLUSH, PIX_W'($urandom));
            end else begin
                send_item(OP_PIXEL, pattern_pixel(kind, col_pos % FRAME_WIDTH));
                col_pos++;
            end
        end
        s_valid <= 1'b0;
        idle_enable = 1'b1;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d transactions (%0d flushes), checked %0d results, %0d saturated",
                 n_sent, n_flush, n_results, n_saturated);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
